[rtl/bmalu_pkg.sv]
// bmalu_pkg: opcodes and mask constants for the bit-manipulation alu
// no dependencies
package bmalu_pkg;

    typedef enum logic [4:0] {
        OP_ANDC   = 5'd0,
        OP_CLZ    = 5'd1,
        OP_CTZ    = 5'd2,
        OP_PCNT   = 5'd3,
        OP_SLO    = 5'd4,
        OP_SRO    = 5'd5,
        OP_ROL    = 5'd6,
        OP_ROR    = 5'd7,
        OP_BEXT   = 5'd8,
        OP_BDEP   = 5'd9,
        OP_GREV   = 5'd10,
        OP_SHFL   = 5'd11,
        OP_UNSHFL = 5'd12,
        OP_CLZW   = 5'd13,
        OP_CTZW   = 5'd14,
        OP_PCNTW  = 5'd15,
        OP_SLOW   = 5'd16,
        OP_SROW   = 5'd17,
        OP_ROLW   = 5'd18,
        OP_RORW   = 5'd19,
        OP_BEXTW  = 5'd20,
        OP_BDEPW  = 5'd21
    } t_op;

    localparam logic [63:0] REV_LO [6] = '{
        64'h5555555555555555, 64'h3333333333333333, 64'h0F0F0F0F0F0F0F0F,
        64'h00FF00FF00FF00FF, 64'h0000FFFF0000FFFF, 64'h00000000FFFFFFFF
    };
    localparam logic [63:0] MIX_L [5] = '{
        64'h4444444444444444, 64'h3030303030303030, 64'h0F000F000F000F00,
        64'h00FF000000FF0000, 64'h0000FFFF00000000
    };
    localparam logic [63:0] MIX_R [5] = '{
        64'h2222222222222222, 64'h0C0C0C0C0C0C0C0C, 64'h00F000F000F000F0,
        64'h0000FF000000FF00, 64'h00000000FFFF0000
    };

endpackage

[rtl/bit_manipulation_alu_unit.sv]
// bit_manipulation_alu_unit: pipelined bit-manipulation alu, top level
// depends on bmalu_pkg
//
// Bit-manipulation execution unit: and-with-complement, leading/trailing
// zero and population counts, shift-ones, rotates, bit extract and deposit,
// generalized reverse, shuffle/unshuffle, plus the 32-bit word forms
// (opcodes 13..21, zero when XLEN is 32). One transfer is taken every cycle
// while o_stall is low. Stage 1 does operand prep and masking, stages 2 and 3
// split the longer counting, rank and permutation networks, stage 4 does the
// final select into the output register. Stall from the output side freezes
// the whole pipe, except that bubbles are squeezed out so a stage that holds
// no item always takes a new one.
module bit_manipulation_alu_unit
    import bmalu_pkg::*;
#(
    parameter int XLEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_opcode,
    input  logic [63:0] i_source_a,
    input  logic [63:0] i_source_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result
);

    localparam int SW = $clog2(XLEN);
    localparam logic [63:0] XMASK = (XLEN >= 64) ? {64{1'b1}}
                                    : ((64'd1 << XLEN) - 64'd1);
    localparam bit WIDE = (XLEN >= 64);

    // ---------------- handshake: per-stage advance with bubble squeeze
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    assign adv4 = !r_v4 || !i_stall;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: operand masking and word selection
    // the word forms reuse the full-width datapath with w = 32
    logic        n_w32;
    logic [63:0] n_a, n_b;
    logic [5:0]  n_sh;
    always_comb begin
        n_w32 = (i_opcode >= OP_CLZW);
        n_a   = n_w32 ? {32'd0, i_source_a[31:0]} : (i_source_a & XMASK);
        n_b   = n_w32 ? {32'd0, i_source_b[31:0]} : (i_source_b & XMASK);
        n_sh  = n_w32 ? {1'b0, i_source_b[4:0]}
                      : 6'(i_source_b[SW-1:0]);
    end

    logic [4:0]  r1_op;
    logic        r1_w32;
    logic [63:0] r1_a, r1_b;
    logic [5:0]  r1_sh;
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_op  <= i_opcode;
            r1_w32 <= n_w32;
            r1_a   <= n_a;
            r1_b   <= n_b;
            r1_sh  <= n_sh;
        end
    end

    // ---------------- stage 2: simple ops, first half of counts/permutes
    // width mask of the current operand
    logic [63:0] wm1;
    assign wm1 = r1_w32 ? 64'h00000000FFFFFFFF : XMASK;

    // ones count per byte, leading/trailing zero per byte
    logic [3:0] n_bpc [8];
    logic [3:0] n_bclz [8];
    logic [3:0] n_bctz [8];
    // ones count of the select mask per byte, the input to the rank prefix
    logic [3:0] n_mcnt [8];
    logic [63:0] n_simple;
    logic [63:0] n_rev;
    logic [63:0] n_shf;
    logic [63:0] n_lz_src;
    always_comb begin
        logic [63:0] x;
        logic [5:0]  s;
        logic [4:0]  c;
        logic [6:0]  wd;
        wd = r1_w32 ? 7'd32 : 7'(XLEN);
        s  = r1_sh;
        // leading zeros measured on a value aligned to bit 63
        n_lz_src = r1_w32 ? {r1_a[31:0], 32'hFFFFFFFF}
                 : (XLEN >= 64 ? r1_a : (r1_a << (64 - XLEN)) | ~({64{1'b1}} << (64 - XLEN)));
        for (int i = 0; i < 8; i++) begin
            n_bpc[i]  = 4'($countones(r1_a[8*i +: 8]));
            n_mcnt[i] = 4'($countones(r1_b[8*i +: 8]));
            n_bclz[i] = 4'd8;
            n_bctz[i] = 4'd8;
            for (int j = 0; j < 8; j++) begin
                if (n_lz_src[8*i+j]) n_bclz[i] = 4'(7 - j);
                if (r1_a[8*i+7-j]) n_bctz[i] = 4'(7 - j);
            end
        end
        // and-with-complement, shift-ones and rotates
        n_simple = '0;
        case (r1_op)
            OP_ANDC: n_simple = r1_a & ~r1_b;
            OP_SLO, OP_SLOW: n_simple = ~((~r1_a) << s) & wm1;
            OP_SRO, OP_SROW: n_simple = ~(((~r1_a) & wm1) >> s) & wm1;
            OP_ROL, OP_ROLW:
                n_simple = (s == 6'd0) ? r1_a
                         : ((r1_a << s) | (r1_a >> (wd - 7'(s)))) & wm1;
            OP_ROR, OP_RORW:
                n_simple = (s == 6'd0) ? r1_a
                         : ((r1_a >> s) | (r1_a << (wd - 7'(s)))) & wm1;
            default: n_simple = '0;
        endcase
        // generalized reverse
        x = r1_a;
        for (int k = 0; k < 6; k++) begin
            if ((1 << k) < XLEN && s[k])
                x = ((x & REV_LO[k]) << (1 << k)) | ((x & ~REV_LO[k]) >> (1 << k));
        end
        n_rev = x & XMASK;
        // shuffle and unshuffle
        c = r1_b[4:0];
        x = r1_a;
        if (r1_op == OP_SHFL) begin
            for (int k = 4; k >= 0; k--)
                if ((2 << k) < XLEN && c[k])
                    x = (x & ~(MIX_L[k] | MIX_R[k])) | ((x << (1 << k)) & MIX_L[k])
                      | ((x >> (1 << k)) & MIX_R[k]);
        end else begin
            for (int k = 0; k < 5; k++)
                if ((2 << k) < XLEN && c[k])
                    x = (x & ~(MIX_L[k] | MIX_R[k])) | ((x << (1 << k)) & MIX_L[k])
                      | ((x >> (1 << k)) & MIX_R[k]);
        end
        n_shf = x & XMASK;
    end

    logic [4:0]  r2_op;
    logic        r2_w32;
    logic [63:0] r2_a, r2_b, r2_res;
    logic [3:0]  r2_bpc [8];
    logic [3:0]  r2_bclz [8];
    logic [3:0]  r2_bctz [8];
    logic [3:0]  r2_mcnt [8];
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_op  <= r1_op;
            r2_w32 <= r1_w32;
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_bpc <= n_bpc;
            r2_bclz <= n_bclz;
            r2_bctz <= n_bctz;
            r2_mcnt <= n_mcnt;
            case (r1_op)
                OP_GREV: r2_res <= n_rev;
                OP_SHFL, OP_UNSHFL: r2_res <= n_shf;
                default: r2_res <= n_simple;
            endcase
        end
    end

    // ---------------- stage 3: byte prefix sums, per-byte extract/deposit
    logic [6:0] n_cnt, n_clz, n_ctz;
    logic [6:0] n_base [8];
    logic [7:0] n_gbyte [8];
    logic [7:0] n_dbyte [8];
    always_comb begin
        logic [6:0] acc;
        logic [3:0] j;
        logic       done;
        n_cnt = '0;
        for (int i = 0; i < 8; i++) n_cnt = n_cnt + 7'(r2_bpc[i]);
        n_clz = '0;
        done  = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!done) n_clz = n_clz + 7'(r2_bclz[i]);
            if (r2_bclz[i] != 4'd8) done = 1'b1;
        end
        n_ctz = '0;
        done  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!done) n_ctz = n_ctz + 7'(r2_bctz[i]);
            if (r2_bctz[i] != 4'd8) done = 1'b1;
        end
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            n_base[i] = acc;
            acc = acc + 7'(r2_mcnt[i]);
        end
        // byte-local extract and deposit
        for (int i = 0; i < 8; i++) begin
            n_gbyte[i] = '0;
            n_dbyte[i] = '0;
            j = '0;
            for (int k = 0; k < 8; k++) begin
                if (r2_b[8*i+k]) begin
                    n_gbyte[i][j[2:0]] = r2_a[8*i+k];
                    n_dbyte[i][k] = r2_a[6'(n_base[i] + 7'(j))];
                    j = j + 4'd1;
                end
            end
        end
    end

    logic [4:0]  r3_op;
    logic        r3_w32;
    logic [63:0] r3_res;
    logic [6:0]  r3_cnt, r3_clz, r3_ctz;
    logic [6:0]  r3_base [8];
    logic [7:0]  r3_gbyte [8];
    logic [63:0] r3_dep;
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_op  <= r2_op;
            r3_w32 <= r2_w32;
            r3_res <= r2_res;
            r3_cnt <= n_cnt;
            r3_clz <= n_clz;
            r3_ctz <= n_ctz;
            r3_base <= n_base;
            r3_gbyte <= n_gbyte;
            for (int i = 0; i < 8; i++) r3_dep[8*i +: 8] <= n_dbyte[i];
        end
    end

    // ---------------- stage 4: pack extract bytes, final select
    logic [63:0] n_ext, n_res;
    logic [6:0]  wbits;
    always_comb begin
        n_ext = '0;
        for (int i = 0; i < 8; i++)
            n_ext = n_ext | ({56'd0, r3_gbyte[i]} << r3_base[i][5:0]);
        wbits = r3_w32 ? 7'd32 : 7'(XLEN);
        case (r3_op)
            OP_CLZ, OP_CLZW: n_res = {57'd0, (r3_clz > wbits) ? wbits : r3_clz};
            OP_CTZ, OP_CTZW: n_res = {57'd0, (r3_ctz > wbits) ? wbits : r3_ctz};
            OP_PCNT, OP_PCNTW: n_res = {57'd0, r3_cnt};
            OP_BEXT, OP_BEXTW: n_res = n_ext;
            OP_BDEP, OP_BDEPW: n_res = r3_dep;
            OP_ANDC, OP_SLO, OP_SRO, OP_ROL, OP_ROR, OP_GREV, OP_SHFL, OP_UNSHFL,
            OP_SLOW, OP_SROW, OP_ROLW, OP_RORW: n_res = r3_res;
            default: n_res = '0;
        endcase
        // word forms do not exist on a 32-bit core
        if (!WIDE && r3_op >= OP_CLZW) n_res = '0;
        n_res = n_res & XMASK;
    end

    always_ff @(posedge i_clk) begin
        if (adv4) o_result <= n_res;
    end

    // ---------------- checks
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed under stall");
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("stall with empty entry stage");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_stall |=> r_v4)
        else $error("item lost between stage 3 and output");
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result & ~XMASK) == 64'd0)
        else $error("result bits above xlen");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for the bit-manipulation alu unit (XLEN = 64)
// depends on bmalu_pkg and bit_manipulation_alu_unit
module tb;
    import bmalu_pkg::*;

    // directed row: opcode, operands, and a typed-in result where it is obvious
    typedef struct {
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
        bit          has_fixed;
        logic [63:0] fixed;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [4:0]  i_opcode = '0;
    logic [63:0] i_source_a = '0;
    logic [63:0] i_source_b = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_result;

    logic [63:0] result_q[$];
    int          n_err = 0;
    int          n_sent = 0;
    int          n_got = 0;
    bit          calm = 1'b0;   // long stretch with no idling on either side

    always #5 i_clk = ~i_clk;

    bit_manipulation_alu_unit #(.XLEN(64)) uut (.*);

    // -------- predictor helpers, w = operand width (64 or 32) --------
    function automatic logic [63:0] wm(int w);
        return (w == 64) ? '1 : 64'h00000000FFFFFFFF;
    endfunction

    function automatic logic [63:0] lead0(logic [63:0] x, int w);
        int n;
        n = 0;
        while (n < w && x[w-1-n] == 1'b0) n++;
        return 64'(n);
    endfunction

    function automatic logic [63:0] trail0(logic [63:0] x, int w);
        int n;
        n = 0;
        while (n < w && x[n] == 1'b0) n++;
        return 64'(n);
    endfunction

    function automatic logic [63:0] ones(logic [63:0] x, int w);
        int n;
        n = 0;
        for (int i = 0; i < w; i++) n += x[i];
        return 64'(n);
    endfunction

    // rotate or fill: rot=1 rotates, else ones shift in; left selects direction
    function automatic logic [63:0] shift_op(logic [63:0] x, logic [63:0] b, int w,
                                             bit left, bit rot);
        int          s;
        logic [63:0] m;
        logic [63:0] r;
        s = int'(b[5:0] & 6'(w - 1));
        m = wm(w);
        x = x & m;
        if (s == 0) return x;
        if (rot) r = left ? ((x << s) | (x >> (w - s))) : ((x >> s) | (x << (w - s)));
        else r = left ? ~((~x) << s) : ~((~x & m) >> s);
        return r & m;
    endfunction

    function automatic logic [63:0] extract(logic [63:0] x, logic [63:0] sel, int w);
        logic [63:0] r;
        int          j;
        r = '0;
        j = 0;
        for (int i = 0; i < w; i++)
            if (sel[i]) begin
                r[j] = x[i];
                j++;
            end
        return r;
    endfunction

    function automatic logic [63:0] deposit(logic [63:0] x, logic [63:0] sel, int w);
        logic [63:0] r;
        int          j;
        r = '0;
        j = 0;
        for (int i = 0; i < w; i++)
            if (sel[i]) begin
                r[i] = x[j];
                j++;
            end
        return r;
    endfunction

    function automatic logic [63:0] grev(logic [63:0] x, logic [63:0] b);
        for (int k = 0; k < 6; k++)
            if (b[k]) x = ((x & REV_LO[k]) << (1 << k)) | ((x & ~REV_LO[k]) >> (1 << k));
        return x;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] x, int k);
        int n;
        n = 1 << k;
        return (x & ~(MIX_L[k] | MIX_R[k])) | ((x << n) & MIX_L[k]) | ((x >> n) & MIX_R[k]);
    endfunction

    // shuffle applies the stages high to low, unshuffle low to high
    function automatic logic [63:0] shuffle(logic [63:0] x, logic [63:0] b, bit inv);
        for (int i = 0; i < 5; i++) begin
            int k;
            k = inv ? i : 4 - i;
            if (b[k]) x = mix(x, k);
        end
        return x;
    endfunction

    function automatic logic [63:0] alu_result(logic [4:0] op, logic [63:0] a,
                                               logic [63:0] b);
        logic [63:0] a32;
        logic [63:0] b32;
        a32 = a & 64'hFFFFFFFF;
        b32 = b & 64'hFFFFFFFF;
        case (op)
            OP_ANDC:   return a & ~b;
            OP_CLZ:    return lead0(a, 64);
            OP_CTZ:    return trail0(a, 64);
            OP_PCNT:   return ones(a, 64);
            OP_SLO:    return shift_op(a, b, 64, 1'b1, 1'b0);
            OP_SRO:    return shift_op(a, b, 64, 1'b0, 1'b0);
            OP_ROL:    return shift_op(a, b, 64, 1'b1, 1'b1);
            OP_ROR:    return shift_op(a, b, 64, 1'b0, 1'b1);
            OP_BEXT:   return extract(a, b, 64);
            OP_BDEP:   return deposit(a, b, 64);
            OP_GREV:   return grev(a, b);
            OP_SHFL:   return shuffle(a, b, 1'b0);
            OP_UNSHFL: return shuffle(a, b, 1'b1);
            OP_CLZW:   return lead0(a32, 32);
            OP_CTZW:   return trail0(a32, 32);
            OP_PCNTW:  return ones(a32, 32);
            OP_SLOW:   return shift_op(a32, b32, 32, 1'b1, 1'b0);
            OP_SROW:   return shift_op(a32, b32, 32, 1'b0, 1'b0);
            OP_ROLW:   return shift_op(a32, b32, 32, 1'b1, 1'b1);
            OP_RORW:   return shift_op(a32, b32, 32, 1'b0, 1'b1);
            OP_BEXTW:  return extract(a32, b32, 32);
            OP_BDEPW:  return deposit(a32, b32, 32);
            default:   return '0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        // skew some operands toward sparse/dense patterns to hit count corners
        case ($urandom_range(0, 5))
            0: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            1: v = v | {$urandom, $urandom} | {$urandom, $urandom};
            2: v = v >> $urandom_range(0, 63);
            3: v = v << $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    // -------- output side: random stall, compare against oldest prediction --------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_got++;
            if (result_q.size() == 0) begin
                $error("unexpected result %h", o_result);
                n_err++;
            end else begin
                logic [63:0] want;
                want = result_q.pop_front();
                if (o_result !== want) begin
                    $error("result mismatch: expected %h actual %h", want, o_result);
                    n_err++;
                end
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    // one transfer: idle at random, present the item, wait until it is taken
    task automatic send_item(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                             bit has_fixed, logic [63:0] fixed);
        logic [63:0] want;
        while (!calm && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_source_a <= a;
        i_source_b <= b;
        want = alu_result(op, a, b);
        if (has_fixed && fixed !== want) begin
            $error("directed row %0d: table %h vs predictor %h", n_sent, fixed, want);
            n_err++;
        end
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge
        result_q.push_back(has_fixed ? fixed : want);
        n_sent++;
    endtask

    t_row rows[$];

    initial begin
        // extremes, every opcode, all-zero counts, masked shift amounts
        rows = '{
            '{OP_ANDC,   '1,                  '0,          1, '1},
            '{OP_ANDC,   '1,                  '1,          1, '0},
            '{OP_CLZ,    '0,                  '0,          1, 64},
            '{OP_CLZ,    '1,                  '0,          1, 0},
            '{OP_CTZ,    '0,                  '0,          1, 64},
            '{OP_CTZ,    64'h8000000000000000,'0,          1, 63},
            '{OP_PCNT,   '1,                  '0,          1, 64},
            '{OP_SLO,    '0,                  64'd63,      1, 64'h7FFFFFFFFFFFFFFF},
            '{OP_SRO,    '0,                  64'd127,     1, 64'hFFFFFFFFFFFFFFFE},
            '{OP_ROL,    64'h8000000000000001,64'd1,       1, 64'h3},
            '{OP_ROR,    64'h1,               '1,          1, 64'h2},
            '{OP_BEXT,   '1,                  '1,          1, '1},
            '{OP_BDEP,   '1,                  64'hF0,      1, 64'hF0},
            '{OP_GREV,   64'h0123456789ABCDEF,64'd63,      0, '0},
            '{OP_SHFL,   64'hFFFFFFFF00000000,64'd31,      0, '0},
            '{OP_UNSHFL, 64'hAAAAAAAAAAAAAAAA,64'd31,      0, '0},
            '{OP_CLZW,   64'hFFFFFFFF00000000,'0,          1, 32},
            '{OP_CTZW,   64'hFFFFFFFF00000000,'0,          1, 32},
            '{OP_PCNTW,  '1,                  '0,          1, 32},
            '{OP_SLOW,   '0,                  64'h3F,      1, 64'h7FFFFFFF},
            '{OP_SROW,   '0,                  64'h1,       1, 64'h80000000},
            '{OP_ROLW,   64'h80000000,        '1,          1, 64'h40000000},
            '{OP_RORW,   '1,                  64'd5,       1, 64'hFFFFFFFF},
            '{OP_BEXTW,  '1,                  '1,          1, 64'hFFFFFFFF},
            '{OP_BDEPW,  '1,                  '1,          1, 64'hFFFFFFFF}
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_item(rows[i].op, rows[i].a, rows[i].b,
                                    rows[i].has_fixed, rows[i].fixed);
        // unused opcodes give zero
        for (int op = 22; op < 32; op++) send_item(5'(op), rand64(), rand64(), 1'b1, '0);

        for (int i = 0; i < 1250; i++) begin
            calm = (i >= 500 && i < 700);
            send_item(5'($urandom_range(0, 22) == 22 ? $urandom_range(22, 31)
                                                    : $urandom_range(0, 21)),
                      rand64(), rand64(), 1'b0, '0);
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("covered %0d transfers in, %0d results checked, all opcodes incl. unused",
                 n_sent, n_got);
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // safety net well above the slowest correct run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
